// File: src/dtl_pkg.sv
// ----------------------------------------------------------------------------
// dtl_pkg: shared types and constants for the timed light controller
// Holds the item payload types, register indexes, widths and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtl_pkg;

    localparam int DebounceW = 16;
    localparam int OnTimeW   = 32;
    localparam int RunW      = 17;
    localparam int CfgDataW  = 32;
    localparam int CfgIdxW   = 3;

    localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TICKS    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ON_TIME_TICKS     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_INPUT_ACTIVE_LOW  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_OUTPUT_ACTIVE_LOW = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TARGET_IS_LOCAL   = 3'd4;

    localparam logic [DebounceW-1:0] DEBOUNCE_RESET = 16'd80;
    localparam logic [OnTimeW-1:0]   ON_TIME_RESET  = 32'd60000;
    localparam logic [RunW-1:0]      RUN_MAX        = {RunW{1'b1}};

    typedef struct packed {
        logic raw_level;
        logic remote_request;
    } in_item_t;

    typedef struct packed {
        logic drive_level;
        logic light_is_on;
        logic send_remote;
        logic press_seen;
    } out_item_t;

endpackage

// File: src/dtl_stream_if.sv
// ----------------------------------------------------------------------------
// dtl_stream_if: valid/ready channel carrying one item payload
// The payload type is set per instance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dtl_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/dtl_debounce.sv
// ----------------------------------------------------------------------------
// dtl_debounce: run counter and arm flag for the pushbutton
// Fires one press when an armed button stays active beyond the threshold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtl_debounce (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic                           active,
    input  logic [dtl_pkg::DebounceW-1:0]  debounce_ticks,
    output logic                           press
);

    logic [dtl_pkg::RunW-1:0] run_count_reg;
    logic [dtl_pkg::RunW-1:0] run_count_next;
    logic                     armed_reg;
    logic                     armed_next;

    always_comb
    begin
        run_count_next = run_count_reg;
        armed_next     = armed_reg;
        press          = 1'b0;
        if (!active)
        begin
            run_count_next = '0;
            armed_next     = 1'b1;
        end
        else
        begin
            if (run_count_reg != dtl_pkg::RUN_MAX)
            begin
                run_count_next = run_count_reg + 1'b1;
            end
            if (armed_reg && (run_count_next > {1'b0, debounce_ticks}))
            begin
                press      = 1'b1;
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= '0;
            armed_reg     <= 1'b0;
        end
        else if (step)
        begin
            run_count_reg <= run_count_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

// File: src/debounced_toggle_timed_light.sv
// An accepted item waits in the input register until its result item can be loaded into the result register.
// Throughput: one item per cycle; the input register and the result register each
// advance whenever the result register is empty or its item is being taken.
// Reset: rst_n clears both valid flags, the debounce counter, the arm flag, the light
// and its timer, and loads the configuration registers with their documented defaults.
// ----------------------------------------------------------------------------
// debounced_toggle_timed_light: pushbutton to staircase light controller
// Each item is one timebase tick. The button level is debounced, a press
// toggles the local light or is forwarded as a remote pulse, and the light
// switches itself off after the programmed on-time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounced_toggle_timed_light (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [dtl_pkg::CfgIdxW-1:0]   wr_index,
    input  logic [dtl_pkg::CfgDataW-1:0]  wr_data,
    dtl_stream_if.sink                    in_ch,
    dtl_stream_if.source                  out_ch
);

    // Configuration registers. They must only be written while the block is idle; the block does not enforce this.
    logic [dtl_pkg::DebounceW-1:0] debounce_ticks_reg;
    logic [dtl_pkg::OnTimeW-1:0]   on_time_ticks_reg;
    logic                          input_active_low_reg;
    logic                          output_active_low_reg;
    logic                          target_is_local_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg    <= dtl_pkg::DEBOUNCE_RESET;
            on_time_ticks_reg     <= dtl_pkg::ON_TIME_RESET;
            input_active_low_reg  <= 1'b0;
            output_active_low_reg <= 1'b0;
            target_is_local_reg   <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                dtl_pkg::REG_DEBOUNCE_TICKS:
                    debounce_ticks_reg <= wr_data[dtl_pkg::DebounceW-1:0];
                dtl_pkg::REG_ON_TIME_TICKS:
                    on_time_ticks_reg <= wr_data[dtl_pkg::OnTimeW-1:0];
                dtl_pkg::REG_INPUT_ACTIVE_LOW:
                    input_active_low_reg <= wr_data[0];
                dtl_pkg::REG_OUTPUT_ACTIVE_LOW:
                    output_active_low_reg <= wr_data[0];
                dtl_pkg::REG_TARGET_IS_LOCAL:
                    target_is_local_reg <= wr_data[0];
                default:
                    ;  // Indexes past the register list are ignored.
            endcase
        end
    end

    // Pipeline control. The tick in the input register is processed, and the
    // light state updated, in the same cycle that its result is loaded into
    // the result register, so consecutive ticks see each other's effects.
    logic               in_valid_reg;
    dtl_pkg::in_item_t  in_item_reg;
    logic               out_valid_reg;
    dtl_pkg::out_item_t out_item_reg;
    dtl_pkg::out_item_t out_item_next;
    logic               advance;
    logic               step;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign step        = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            in_item_reg <= in_ch.payload;
        end
    end

    // Debounce of the polarity-corrected button level.
    logic active;
    logic press;

    assign active = in_item_reg.raw_level ^ input_active_low_reg;

    dtl_debounce u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .active         (active),
        .debounce_ticks (debounce_ticks_reg),
        .press          (press)
    );

    // Light state and its on-time countdown. A press and a remote request in
    // the same tick count as a single toggle.
    logic                        light_reg;
    logic                        light_next;
    logic [dtl_pkg::OnTimeW-1:0] remaining_reg;
    logic [dtl_pkg::OnTimeW-1:0] remaining_next;
    logic                        request;

    assign request = (press && target_is_local_reg) || in_item_reg.remote_request;

    always_comb
    begin
        light_next     = light_reg;
        remaining_next = remaining_reg;
        if (!light_reg)
        begin
            if (request)
            begin
                light_next     = 1'b1;
                remaining_next = on_time_ticks_reg;
            end
        end
        else if (request)
        begin
            light_next     = 1'b0;
            remaining_next = '0;
        end
        else if (remaining_reg == '0)
        begin
            // On-time has run out: switch off by itself.
            light_next = 1'b0;
        end
        else
        begin
            remaining_next = remaining_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg     <= 1'b0;
            remaining_reg <= '0;
        end
        else if (step)
        begin
            light_reg     <= light_next;
            remaining_reg <= remaining_next;
        end
    end

    // Result register.
    always_comb
    begin
        out_item_next.drive_level = light_next ^ output_active_low_reg;
        out_item_next.light_is_on = light_next;
        out_item_next.send_remote = press && !target_is_local_reg;
        out_item_next.press_seen  = press;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

endmodule

// File: tb/debounced_toggle_timed_light_tb.sv
// ----------------------------------------------------------------------------
// debounced_toggle_timed_light_tb: self-checking bench for the light controller
// Drives button and remote ticks through the valid/ready input channel with
// random gaps and output stalls, predicts every result item from a local copy
// of the debounce and timer state, and compares the results field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module debounced_toggle_timed_light_tb;

    // Writes to an index past the last register must leave every register alone.
    localparam logic [dtl_pkg::CfgIdxW-1:0] REG_FIRST_UNUSED =
        dtl_pkg::REG_TARGET_IS_LOCAL + 1'b1;
    localparam logic [dtl_pkg::CfgIdxW-1:0] REG_LAST_UNUSED  = {dtl_pkg::CfgIdxW{1'b1}};

    // Cycles with no item moving on either side before the run is declared hung.
    // The longest legal quiet stretch is the deliberate output hold-off below.
    localparam int WATCHDOG_LIMIT = 2000;
    // Tail waited after the last result, so that the block is truly idle.
    localparam int DRAIN_CYCLES   = 4;
    localparam int HOLD_OFF_LEN   = 120;
    // A held button that stays well below the largest debounce threshold.
    localparam int LONG_HOLD_TICKS = 40;

    logic clk;
    logic rst_n;
    logic wr_en;
    logic [dtl_pkg::CfgIdxW-1:0]  wr_index;
    logic [dtl_pkg::CfgDataW-1:0] wr_data;

    dtl_stream_if #(.payload_t(dtl_pkg::in_item_t))  in_ch ();
    dtl_stream_if #(.payload_t(dtl_pkg::out_item_t)) out_ch ();

    debounced_toggle_timed_light u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .in_ch    (in_ch),
        .out_ch   (out_ch)
    );

    // Free-running clock, 4 ns period.
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // ------------------------------------------------------------------------
    // Predictor state. The configuration copy is updated by the register
    // writer; the light state is advanced once for every accepted tick.
    // ------------------------------------------------------------------------
    logic [dtl_pkg::DebounceW-1:0] cfg_debounce  = dtl_pkg::DEBOUNCE_RESET;
    logic [dtl_pkg::OnTimeW-1:0]   cfg_on_time   = dtl_pkg::ON_TIME_RESET;
    logic                          cfg_in_low    = 1'b0;
    logic                          cfg_out_low   = 1'b0;
    logic                          cfg_to_local  = 1'b1;

    logic [dtl_pkg::RunW-1:0]      st_run        = '0;
    logic                          st_armed      = 1'b0;
    logic                          st_light      = 1'b0;
    logic [dtl_pkg::OnTimeW-1:0]   st_remaining  = '0;

    dtl_pkg::out_item_t light_expected_q[$];
    dtl_pkg::out_item_t light_expected;

    int mismatch_count   = 0;
    int results_seen     = 0;
    int ticks_sent       = 0;
    int quiet_cycles     = 0;
    int src_idle_max     = 8;
    int snk_idle_max     = 8;
    int snk_hold_request = 0;

    // Advances the debounce and light state by one tick and returns the
    // result item that tick should produce.
    function automatic dtl_pkg::out_item_t light_tick(input dtl_pkg::in_item_t tick);
        logic               active;
        logic               press;
        logic               toggle;
        dtl_pkg::out_item_t res;

        active = tick.raw_level ^ cfg_in_low;
        press  = 1'b0;

        // An inactive sample re-arms the button; an armed button that stays
        // active beyond the debounce threshold fires once and disarms.
        if (!active)
        begin
            st_run   = '0;
            st_armed = 1'b1;
        end
        else
        begin
            if (st_run != dtl_pkg::RUN_MAX)
                st_run = st_run + 1'b1;
            if (st_armed && (st_run > cfg_debounce))
            begin
                press    = 1'b1;
                st_armed = 1'b0;
            end
        end

        // A local press and a remote request on the same tick merge into a
        // single toggle.
        toggle = (press & cfg_to_local) | tick.remote_request;

        if (!st_light)
        begin
            if (toggle)
            begin
                st_light     = 1'b1;
                st_remaining = cfg_on_time;
            end
        end
        else if (toggle)
        begin
            st_light     = 1'b0;
            st_remaining = '0;
        end
        else if (st_remaining == '0)
            st_light = 1'b0;
        else
            st_remaining = st_remaining - 1'b1;

        res.drive_level = st_light ^ cfg_out_low;
        res.light_is_on = st_light;
        res.send_remote = press & ~cfg_to_local;
        res.press_seen  = press;
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: result %0d: %s", $time, results_seen, what);
        mismatch_count++;
    endtask

    task automatic compare_field(input string field, input logic got, input logic want);
        if (got !== want)
            report_mismatch($sformatf("%s is %b, expected %b", field, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Monitor and scoreboard. Both channels are sampled at the rising edge,
    // before any of this edge's updates land, so accepted items are seen
    // exactly as the block saw them.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                light_expected_q.push_back(light_tick(in_ch.payload));

            if (out_ch.valid && out_ch.ready)
            begin
                if (light_expected_q.size() == 0)
                    report_mismatch("result item arrived with nothing expected");
                else
                begin
                    light_expected = light_expected_q.pop_front();
                    compare_field("drive_level", out_ch.payload.drive_level,
                                  light_expected.drive_level);
                    compare_field("light_is_on", out_ch.payload.light_is_on,
                                  light_expected.light_is_on);
                    compare_field("send_remote", out_ch.payload.send_remote,
                                  light_expected.send_remote);
                    compare_field("press_seen", out_ch.payload.press_seen,
                                  light_expected.press_seen);
                end
                results_seen++;
            end
        end
    end

    // Watchdog: a long run of cycles in which no item moves on either side
    // means the block has hung.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("debounced_toggle_timed_light verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Before each item it stalls for a random number of
    // cycles, or for the full hold-off when a test asks for one, then keeps
    // ready high until an item is taken.
    // ------------------------------------------------------------------------
    initial
    begin : result_receiver
        int stall;

        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = (snk_idle_max == 0) ? 0 : $urandom_range(snk_idle_max, 0);
            if (snk_hold_request > 0)
            begin
                stall            = snk_hold_request;
                snk_hold_request = 0;
            end
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_ch.valid);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. All of them are entered and left on a rising edge.
    // ------------------------------------------------------------------------

    // Offers one tick after a random gap and returns at the edge that takes it.
    // Valid is left high so that a back-to-back tick keeps it high; the next
    // call or the drain lowers it.
    task automatic send_tick(input logic raw, input logic remote);
        int gap;

        gap = (src_idle_max == 0) ? 0 : $urandom_range(src_idle_max, 0);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid                  <= 1'b1;
        in_ch.payload.raw_level      <= raw;
        in_ch.payload.remote_request <= remote;
        do
            @(posedge clk);
        while (!in_ch.ready);
        ticks_sent++;
    endtask

    // Sends a tick in terms of button activity, so that the pin level follows
    // the current input polarity. Remote requests are rare.
    task automatic press_level(input logic active);
        send_tick(active ^ cfg_in_low, $urandom_range(15, 0) == 0);
    endtask

    // Stops offering and waits until every expected result has come back,
    // plus a short tail so the block is idle before the next register write.
    task automatic wait_results_done();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (light_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [dtl_pkg::CfgIdxW-1:0]  idx,
                           input logic [dtl_pkg::CfgDataW-1:0] data);
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
    endtask

    // Writes all five registers, with junk above the width of every register narrower than
    // the data word, then one index past the list, which the block must ignore.
    task automatic apply_config(input logic [dtl_pkg::DebounceW-1:0] debounce,
                                input logic [dtl_pkg::OnTimeW-1:0]   on_time,
                                input logic in_low, input logic out_low,
                                input logic to_local);
        wr_en <= 1'b1;
        put_reg(dtl_pkg::REG_DEBOUNCE_TICKS,    {16'($urandom()), debounce});
        put_reg(dtl_pkg::REG_ON_TIME_TICKS,     on_time);
        put_reg(dtl_pkg::REG_INPUT_ACTIVE_LOW,  {31'($urandom()), in_low});
        put_reg(dtl_pkg::REG_OUTPUT_ACTIVE_LOW, {31'($urandom()), out_low});
        put_reg(dtl_pkg::REG_TARGET_IS_LOCAL,   {31'($urandom()), to_local});
        put_reg(dtl_pkg::CfgIdxW'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)),
                $urandom());
        wr_en <= 1'b0;

        cfg_debounce = debounce;
        cfg_on_time  = on_time;
        cfg_in_low   = in_low;
        cfg_out_low  = out_low;
        cfg_to_local = to_local;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings. The button is held from reset, so it was never armed
    // and must not fire; remote requests switch the light on and off.
    task automatic test_held_from_reset();
        repeat (6) send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    // Zero debounce fires on the first active tick; zero on-time keeps the
    // light on only for the switching tick; a press together with a remote
    // request toggles once. The drive pin is inverted here.
    task automatic test_zero_settings();
        wait_results_done();
        apply_config('0, '0, 1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    // Active-low button with a remote target: the press only pulses
    // send_remote, a held button fires once, and the on-time runs out.
    task automatic test_remote_target();
        wait_results_done();
        apply_config(16'd1, 32'd2, 1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b0);
    endtask

    // Largest debounce and on-time. A long hold stays far below the
    // threshold and must not fire; a remote request switches the light on,
    // it does not time out over a quiet stretch, and a second request turns
    // it off.
    task automatic test_extreme_hold();
        wait_results_done();
        apply_config({dtl_pkg::DebounceW{1'b1}}, {dtl_pkg::OnTimeW{1'b1}},
                     1'b0, 1'b0, 1'b1);
        src_idle_max = 0;
        snk_idle_max = 0;
        send_tick(1'b0, 1'b0);
        repeat (LONG_HOLD_TICKS) send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        repeat (20) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
    endtask

    // Mostly well-formed presses: a short release followed by a hold close to
    // the debounce threshold, so some presses fall just short and others
    // fire. The rest is pin noise and quiet stretches that let the light
    // time out.
    task automatic test_random_phase(input int n_ticks,
                                     input logic [dtl_pkg::DebounceW-1:0] debounce,
                                     input logic [dtl_pkg::OnTimeW-1:0]   on_time,
                                     input logic in_low, input logic out_low,
                                     input logic to_local, input int idle);
        int first_tick;
        int kind;
        int len;
        int hold_lo;
        int hold_hi;

        wait_results_done();
        apply_config(debounce, on_time, in_low, out_low, to_local);
        src_idle_max = idle;
        snk_idle_max = idle;
        first_tick   = ticks_sent;
        hold_lo      = (debounce > 1) ? int'(debounce) - 1 : 1;
        hold_hi      = int'(debounce) + 3;

        while (ticks_sent - first_tick < n_ticks)
        begin
            kind = $urandom_range(9, 0);
            if (kind < 7)
            begin
                repeat ($urandom_range(3, 1)) press_level(1'b0);
                repeat ($urandom_range(hold_hi, hold_lo)) press_level(1'b1);
            end
            else if (kind < 9)
            begin
                repeat ($urandom_range(6, 1))
                    send_tick(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            end
            else
            begin
                len = (on_time > 37) ? 40 : int'(on_time) + 3;
                repeat (len) send_tick(1'b0 ^ cfg_in_low, 1'b0);
            end
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering ticks back to back, so the block fills and stalls its input.
    // Then the sender pauses until every result has come before going on.
    task automatic test_backpressure();
        wait_results_done();
        apply_config(16'd2, 32'd6, 1'b0, 1'b1, 1'b1);
        src_idle_max     = 0;
        snk_idle_max     = 2;
        snk_hold_request = HOLD_OFF_LEN;
        repeat (20)
        begin
            press_level(1'b0);
            repeat ($urandom_range(4, 1)) press_level(1'b1);
        end
        wait_results_done();
        src_idle_max = 8;
        snk_idle_max = 8;
        repeat (10)
        begin
            press_level(1'b0);
            repeat ($urandom_range(4, 1)) press_level(1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        wr_en         <= 1'b0;
        wr_index      <= '0;
        wr_data       <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.payload <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_held_from_reset();
        test_zero_settings();
        test_remote_target();
        test_random_phase(60, 16'd3, 32'd10, 1'b0, 1'b0, 1'b1, 8);
        test_random_phase(40, 16'd0, 32'd0,  1'b1, 1'b1, 1'b0, 0);
        test_random_phase(60, 16'd5, 32'd1,  1'b0, 1'b1, 1'b1, 8);
        test_random_phase(60, 16'd1, 32'd25, 1'b1, 1'b0, 1'b1, 3);
        test_random_phase(40, 16'd9, 32'd4,  1'b0, 1'b0, 1'b0, 8);
        test_backpressure();
        test_extreme_hold();

        wait_results_done();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (light_expected_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      light_expected_q.size()));

        if (mismatch_count == 0)
            $display("debounced_toggle_timed_light verification clean");
        else
            $display("debounced_toggle_timed_light verification failed");
        $finish;
    end

endmodule

// File: filelist.f
src/dtl_pkg.sv
src/dtl_stream_if.sv
src/dtl_debounce.sv
src/debounced_toggle_timed_light.sv
tb/debounced_toggle_timed_light_tb.sv
